// File: rtl/btlpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlpm_pkg: shared types and constants
// Field widths, request modes and the small structs used across the
// longest-prefix-match trie block.
// ----------------------------------------------------------------------------
package btlpm_pkg;

   localparam int ADDR_W = 32;
   localparam int LEN_W  = 6;
   localparam int HOP_W  = 32;
   localparam int PORT_W = 4;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [HOP_W-1:0]  hop;
      logic [PORT_W-1:0] port;
   } route_type;

endpackage

// File: rtl/btlpm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlpm_if: request and response channels
// Valid/ready channels carrying the trie request and its single response.
// ----------------------------------------------------------------------------
interface btlpm_req_if;
   import btlpm_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [ADDR_W-1:0] address;
   logic [LEN_W-1:0]  prefix_len;
   logic [HOP_W-1:0]  route_next_hop;
   logic [PORT_W-1:0] route_port;

   modport source (output valid, mode, address, prefix_len, route_next_hop, route_port,
                   input ready);
   modport sink (input valid, mode, address, prefix_len, route_next_hop, route_port,
                 output ready);
endinterface

interface btlpm_rsp_if;
   import btlpm_pkg::*;
   logic              valid;
   logic              ready;
   logic              hit;
   logic              table_full;
   logic [HOP_W-1:0]  found_next_hop;
   logic [PORT_W-1:0] found_port;
   logic [LEN_W-1:0]  match_len;

   modport source (output valid, hit, table_full, found_next_hop, found_port, match_len,
                   input ready);
   modport sink (input valid, hit, table_full, found_next_hop, found_port, match_len,
                 output ready);
endinterface

// File: rtl/binary_trie_longest_prefix_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match: IPv4 route table as a binary trie
// Insert walks the prefix bits allocating nodes and stores the route at the
// last node; lookup walks the address and returns the deepest valid route.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    mode, address, prefix_len, route_next_hop, route_port
//   rsp_ch   out  valid/ready    hit, table_full, found_next_hop, found_port, match_len
//
// A request is accepted in S_IDLE, then S_WALK visits one trie level per step
// (depth+1 levels, at most ADDR_BITS+1) and S_RESP posts the response.
// The node RAM read port sets the pace of the walk: one node fetched per cycle.
// The root lives in flops; other nodes are only reached after allocation,
// so no clearing pass follows reset. A new request is taken once the last
// response has moved to the output register; a stalled response holds there.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match #(
   parameter int NODES     = 4096,
   parameter int ADDR_BITS = 32
) (
   input logic         clock,
   input logic         reset,
   btlpm_req_if.sink   req_ch,
   btlpm_rsp_if.source rsp_ch
);
   import btlpm_pkg::*;

   localparam int NODE_W  = $clog2(NODES);
   localparam int USED_W  = $clog2(NODES + 1);
   localparam int CHILD_W = 2 * NODE_W;
   localparam int ROUTE_W = $bits(route_type);
   localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(ADDR_BITS);
   localparam logic [USED_W-1:0] USED_FULL = USED_W'(NODES);

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_RESP} state_type;

   state_type           state_ff, state_in;
   logic                mode_ff, mode_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    depth_ff, depth_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic                fresh_ff, fresh_in;
   logic [HOP_W-1:0]    hop_ff, hop_in;
   logic [PORT_W-1:0]   port_ff, port_in;
   logic                best_hit_ff, best_hit_in;
   logic                best_full_ff, best_full_in;
   logic [HOP_W-1:0]    best_hop_ff, best_hop_in;
   logic [PORT_W-1:0]   best_port_ff, best_port_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;
   logic [CHILD_W-1:0]  root_child_ff, root_child_in;
   route_type           root_route_ff, root_route_in;
   logic [USED_W-1:0]   nodes_used_ff, nodes_used_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_full_ff, rsp_full_in;
   logic [HOP_W-1:0]    rsp_hop_ff, rsp_hop_in;
   logic [PORT_W-1:0]   rsp_port_ff, rsp_port_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   logic                 child_wr_en, route_wr_en, rd_en;
   logic [NODE_W-1:0]    child_wr_addr, route_wr_addr;
   logic [CHILD_W-1:0]   child_wr_data, child_rd;
   route_type            route_wr_data, route_rd;
   logic [ROUTE_W-1:0]   route_rd_raw;
   logic [NODE_W-1:0]    rd_addr;

   logic [CHILD_W-1:0]   cur_child, upd_child;
   route_type            cur_route;
   logic [NODE_W-1:0]    child_sel, new_node;
   logic                 head_bit, is_root, accept;
   cell_ctl_type         cell_ctl;
   logic [ADDR_BITS-1:0] chain_bits;

   // address bit chain: cell 0 presents the bit of the current level
   for (genvar i = 0; i < ADDR_BITS; i++) begin : g_cell
      logic next_bit;
      if (i == ADDR_BITS - 1) begin : g_last
         assign next_bit = 1'b0;
      end else begin : g_mid
         assign next_bit = chain_bits[i+1];
      end
      btlpm_bit_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .load_bit (req_ch.address[ADDR_BITS-1-i]),
         .next_bit (next_bit),
         .bit_out  (chain_bits[i])
      );
   end

   btlpm_ram #(.WIDTH(CHILD_W), .DEPTH(NODES)) u_child_ram (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (child_rd)
   );

   btlpm_ram #(.WIDTH(ROUTE_W), .DEPTH(NODES)) u_route_ram (
      .clock   (clock),
      .wr_en   (route_wr_en),
      .wr_addr (route_wr_addr),
      .wr_data (route_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (route_rd_raw)
   );

   assign route_rd = route_type'(route_rd_raw);
   assign head_bit = chain_bits[0];
   assign is_root  = (node_ff == '0);
   assign accept   = req_ch.valid && req_ch.ready;
   assign new_node = nodes_used_ff[NODE_W-1:0];

   always_comb begin
      if (is_root) begin
         cur_child = root_child_ff;
         cur_route = root_route_ff;
      end else if (fresh_ff) begin
         cur_child = '0;
         cur_route = '0;
      end else begin
         cur_child = child_rd;
         cur_route = route_rd;
      end
   end

   assign child_sel = head_bit ? cur_child[CHILD_W-1:NODE_W] : cur_child[NODE_W-1:0];
   assign upd_child = head_bit ? {new_node, cur_child[NODE_W-1:0]}
                               : {cur_child[CHILD_W-1:NODE_W], new_node};

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      len_in        = len_ff;
      depth_in      = depth_ff;
      node_in       = node_ff;
      fresh_in      = fresh_ff;
      hop_in        = hop_ff;
      port_in       = port_ff;
      best_hit_in   = best_hit_ff;
      best_full_in  = best_full_ff;
      best_hop_in   = best_hop_ff;
      best_port_in  = best_port_ff;
      best_len_in   = best_len_ff;
      root_child_in = root_child_ff;
      root_route_in = root_route_ff;
      nodes_used_in = nodes_used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_len_in    = rsp_len_ff;
      cell_ctl      = '0;
      rd_en         = 1'b0;
      rd_addr       = child_sel;
      child_wr_en   = 1'b0;
      child_wr_addr = node_ff;
      child_wr_data = '0;
      route_wr_en   = 1'b0;
      route_wr_addr = node_ff;
      route_wr_data = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cell_ctl.load = 1'b1;
               mode_in       = req_ch.mode;
               len_in        = (req_ch.prefix_len > MAX_LEN) ? MAX_LEN : req_ch.prefix_len;
               depth_in      = '0;
               node_in       = '0;
               fresh_in      = 1'b0;
               hop_in        = req_ch.route_next_hop;
               port_in       = req_ch.route_port;
               best_hit_in   = 1'b0;
               best_full_in  = 1'b0;
               best_hop_in   = '0;
               best_port_in  = '0;
               best_len_in   = '0;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            if (mode_ff == MODE_LOOKUP) begin
               if (cur_route.valid) begin
                  best_hit_in  = 1'b1;
                  best_hop_in  = cur_route.hop;
                  best_port_in = cur_route.port;
                  best_len_in  = depth_ff;
               end
               if (depth_ff == MAX_LEN || child_sel == '0) begin
                  state_in = S_RESP;
               end else begin
                  rd_en          = 1'b1;
                  cell_ctl.shift = 1'b1;
                  node_in        = child_sel;
                  depth_in       = depth_ff + 1'b1;
               end
            end else if (depth_ff == len_ff) begin
               // store the route here; a fresh node also gets its children cleared
               if (is_root) begin
                  root_route_in = '{valid: 1'b1, hop: hop_ff, port: port_ff};
               end else begin
                  route_wr_en   = 1'b1;
                  route_wr_data = '{valid: 1'b1, hop: hop_ff, port: port_ff};
                  child_wr_en   = fresh_ff;
               end
               best_hit_in  = 1'b1;
               best_hop_in  = hop_ff;
               best_port_in = port_ff;
               best_len_in  = len_ff;
               state_in     = S_RESP;
            end else if (child_sel != '0) begin
               rd_en          = 1'b1;
               cell_ctl.shift = 1'b1;
               node_in        = child_sel;
               fresh_in       = 1'b0;
               depth_in       = depth_ff + 1'b1;
            end else if (nodes_used_ff == USED_FULL) begin
               child_wr_en  = fresh_ff && !is_root;
               best_full_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               // allocate: link parent, clear the new node's route
               if (is_root) begin
                  root_child_in = upd_child;
               end else begin
                  child_wr_en   = 1'b1;
                  child_wr_data = upd_child;
               end
               route_wr_en    = 1'b1;
               route_wr_addr  = new_node;
               nodes_used_in  = nodes_used_ff + 1'b1;
               cell_ctl.shift = 1'b1;
               node_in        = new_node;
               fresh_in       = 1'b1;
               depth_in       = depth_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = best_hit_ff;
               rsp_full_in  = best_full_ff;
               rsp_hop_in   = best_hop_ff;
               rsp_port_in  = best_port_ff;
               rsp_len_in   = best_len_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         nodes_used_ff  <= USED_W'(1);
         root_child_ff  <= '0;
         root_route_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         nodes_used_ff  <= nodes_used_in;
         root_child_ff  <= root_child_in;
         root_route_ff  <= root_route_in;
         mode_ff        <= mode_in;
         len_ff         <= len_in;
         depth_ff       <= depth_in;
         node_ff        <= node_in;
         fresh_ff       <= fresh_in;
         hop_ff         <= hop_in;
         port_ff        <= port_in;
         best_hit_ff    <= best_hit_in;
         best_full_ff   <= best_full_in;
         best_hop_ff    <= best_hop_in;
         best_port_ff   <= best_port_in;
         best_len_ff    <= best_len_in;
         rsp_hit_ff     <= rsp_hit_in;
         rsp_full_ff    <= rsp_full_in;
         rsp_hop_ff     <= rsp_hop_in;
         rsp_port_ff    <= rsp_port_in;
         rsp_len_ff     <= rsp_len_in;
      end
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.hit            = rsp_hit_ff;
   assign rsp_ch.table_full     = rsp_full_ff;
   assign rsp_ch.found_next_hop = rsp_hop_ff;
   assign rsp_ch.found_port     = rsp_port_ff;
   assign rsp_ch.match_len      = rsp_len_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff <= USED_FULL && nodes_used_ff != '0)
      else $error("node count out of range");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> depth_ff <= MAX_LEN)
      else $error("walk depth beyond address width");

   a_hit_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_full_ff))
      else $error("response flags both hit and table full");
endmodule

// File: rtl/btlpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlpm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/btlpm_bit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlpm_bit_cell: one stage of the address bit chain
// Holds one key bit; loads from the request or takes its neighbor's bit
// each time the walk descends a level.
// ----------------------------------------------------------------------------
module btlpm_bit_cell (
   input  logic                    clock,
   input  btlpm_pkg::cell_ctl_type ctl,
   input  logic                    load_bit,
   input  logic                    next_bit,
   output logic                    bit_out
);
   import btlpm_pkg::*;

   cell_ctl_type ctl_w;
   logic bit_ff;
   logic bit_in;

   assign ctl_w = ctl;

   always_comb begin
      bit_in = bit_ff;
      if (ctl_w.load) begin
         bit_in = load_bit;
      end else if (ctl_w.shift) begin
         bit_in = next_bit;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;
endmodule
